FILE: rtl/core/pseg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseg_pkg: shared types and constants for the point/segment hit test
// Transaction payload structs, configuration register indexes and widths.
// ----------------------------------------------------------------------------
package pseg_pkg;

  localparam int CoordW     = 24;  // coordinate width, two's complement
  localparam int TolW       = 12;  // tolerance register width
  localparam int TolSqW     = 24;  // squared tolerance register width
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 24;
  localparam int TolReset   = 4;
  localparam int TolSqReset = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegTol   = 2'd0,
    RegTolSq = 2'd1
  } cfg_reg_t;

  // one test: segment endpoints and probe point
  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] probe_x;
    logic signed [CoordW-1:0] probe_y;
  } pseg_in_t;

  // one result
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
  } pseg_out_t;

endpackage

FILE: rtl/core/pseg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseg_div: pipelined restoring divider
// One quotient bit per stage, most significant first. The numerator must be
// below den * 2^QUO_W. Quotient, remainder and divisor leave together.
// ----------------------------------------------------------------------------
module pseg_div #(
  parameter int DEN_W = 50,
  parameter int QUO_W = 34
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [DEN_W+QUO_W-1:0]   num,
  input  logic [DEN_W-1:0]         den,
  output logic                     out_valid,
  output logic [QUO_W-1:0]         quo,
  output logic [DEN_W-1:0]         rem,
  output logic [DEN_W-1:0]         den_out
);

  localparam int RW = DEN_W + QUO_W;

  logic [RW-1:0]    rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             vld_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int J = QUO_W - 1 - k;
    logic [RW-1:0]    rem_i;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] quo_i;
    logic             v_i;
    logic [RW-1:0]    dsh;

    if (k == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign quo_i = '0;
      assign v_i   = in_valid;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign den_i = den_q[k-1];
      assign quo_i = quo_q[k-1];
      assign v_i   = vld_q[k-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = RW'(den_i) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_i;
      end
      den_q[k] <= den_i;
      if (rem_i >= dsh) begin
        rem_q[k] <= rem_i - dsh;
        quo_q[k] <= quo_i | (QUO_W'(1) << J);
      end else begin
        rem_q[k] <= rem_i;
        quo_q[k] <= quo_i;
      end
    end
  end

  assign out_valid = vld_q[QUO_W-1];
  assign quo       = quo_q[QUO_W-1];
  assign rem       = rem_q[QUO_W-1][DEN_W-1:0];
  assign den_out   = den_q[QUO_W-1];

  // remainder ends below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && den_out != '0) |-> (rem_q[QUO_W-1] < RW'(den_out)))
    else $error("divider remainder not below divisor");

  // pipeline comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("divider valid after reset");

  // every output had a matching earlier input
  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, QUO_W))
    else $error("divider output without input");

endmodule

FILE: rtl/core/point_segment_hit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_hit_test: probe point against line segment, fixed point
// Endpoint box test, grown bounding box test, projection onto the line with
// FRAC_BITS fraction bits and a squared distance test.
//
//  channel   signals                          handshake
//  -------   -------------------------------  ------------------------------
//  input     start, busy, item                start & !busy (busy stays low)
//  result    result_valid, result             one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index,  cfg_valid & cfg_ready
//            cfg_data                          (cfg_ready stays high)
//
// One test enters every cycle. The pipelined divider gives one quotient bit
// per stage (CoordW+FRAC_BITS+2 stages).
// Synchronous reset empties the pipeline and restores the registers.
// Results cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module point_segment_hit_test #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pseg_pkg::pseg_in_t             item,
  output logic                           result_valid,
  output pseg_pkg::pseg_out_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pseg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pseg_pkg::CfgDataW-1:0]  cfg_data
);

  import pseg_pkg::*;

  localparam int CW  = CoordW;
  localparam int MW  = CW + 1;               // magnitude of a coordinate difference
  localparam int PRW = 2 * MW;               // products, numerator core, divisor
  localparam int QW  = CW + FRAC_BITS + 2;   // quotient bits
  localparam int RW  = PRW + QW;             // dividend width
  localparam int PW  = CW + FRAC_BITS + 4;   // projected point, fixed point
  localparam int EW  = PW + 1;               // probe-to-projection error
  localparam int LW  = TolW + FRAC_BITS;     // error magnitude limit
  localparam int LAT = QW + 10;

  localparam logic [PW-1:0]       Half = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [PW:0]  CMax = (PW+1)'(2**(CW-1) - 1);
  localparam logic signed [PW:0]  CMin = -CMax - (PW+1)'(1);
  localparam logic signed [EW-1:0] Lim = EW'(1) << LW;

  // per-test data that rides along the pipeline
  typedef struct packed {
    logic                 force_hit;
    logic                 miss;
    logic                 vert;
    logic                 horz;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } side_t;

  // round to nearest, halves away from zero, then saturate
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [PW-1:0] v);
    logic [PW-1:0]      m;
    logic [PW-1:0]      q;
    logic signed [PW:0] r;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    q = (m + Half) >> FRAC_BITS;
    r = v[PW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (r > CMax) r = CMax;
    if (r < CMin) r = CMin;
    return CW'(r);
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [TolW-1:0]   tol;
  logic [TolSqW-1:0] tol_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= TolW'(TolReset);
      tol_sq <= TolSqW'(TolSqReset);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegTol:   tol    <= cfg_data[TolW-1:0];
        RegTolSq: tol_sq <= cfg_data[TolSqW-1:0];
        default:  ;
      endcase
    end
  end

  // stage 0: capture transaction
  logic     v0;
  pseg_in_t in0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    in0 <= item;
  end

  // stage 1: differences, endpoint boxes, grown bounding box
  logic signed [MW-1:0]   a, b, dx, dy, ex2, ey2, tol_s;
  logic signed [CW-1:0]   xlo, xhi, ylo, yhi;
  logic signed [CW+1:0]   xlo_t, xhi_t, ylo_t, yhi_t, xp_w, yp_w;
  logic                   near_s, near_e, in_box;
  side_t                  side1_next;

  always_comb begin
    a     = MW'(in0.end_x)   - MW'(in0.start_x);
    b     = MW'(in0.end_y)   - MW'(in0.start_y);
    dx    = MW'(in0.probe_x) - MW'(in0.start_x);
    dy    = MW'(in0.probe_y) - MW'(in0.start_y);
    ex2   = MW'(in0.probe_x) - MW'(in0.end_x);
    ey2   = MW'(in0.probe_y) - MW'(in0.end_y);
    tol_s = $signed(MW'(tol));
    near_s = (dx <= tol_s) && (dx >= -tol_s) && (dy <= tol_s) && (dy >= -tol_s);
    near_e = (ex2 <= tol_s) && (ex2 >= -tol_s) && (ey2 <= tol_s) && (ey2 >= -tol_s);
    xlo = (in0.start_x < in0.end_x) ? in0.start_x : in0.end_x;
    xhi = (in0.start_x < in0.end_x) ? in0.end_x : in0.start_x;
    ylo = (in0.start_y < in0.end_y) ? in0.start_y : in0.end_y;
    yhi = (in0.start_y < in0.end_y) ? in0.end_y : in0.start_y;
    xlo_t = (CW+2)'(xlo) - $signed((CW+2)'(tol));
    xhi_t = (CW+2)'(xhi) + $signed((CW+2)'(tol));
    ylo_t = (CW+2)'(ylo) - $signed((CW+2)'(tol));
    yhi_t = (CW+2)'(yhi) + $signed((CW+2)'(tol));
    xp_w  = (CW+2)'(in0.probe_x);
    yp_w  = (CW+2)'(in0.probe_y);
    in_box = (xp_w >= xlo_t) && (xp_w <= xhi_t) && (yp_w >= ylo_t) && (yp_w <= yhi_t);

    side1_next.force_hit = near_s || near_e;
    side1_next.miss      = !(near_s || near_e) && !in_box;
    side1_next.vert      = (in0.start_x == in0.end_x);
    side1_next.horz      = (in0.start_y == in0.end_y);
    side1_next.neg_x     = 1'b0;
    side1_next.neg_y     = 1'b0;
    side1_next.bx        = (!near_s && near_e) ? in0.end_x : in0.start_x;
    side1_next.by        = (!near_s && near_e) ? in0.end_y : in0.start_y;
    side1_next.px        = in0.probe_x;
    side1_next.py        = in0.probe_y;
  end

  logic            v1;
  side_t           side1;
  logic [MW-1:0]   am1, bm1, dxm1, dym1;
  logic            an1, bn1, dxn1, dyn1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    side1 <= side1_next;
    am1   <= a[MW-1]  ? MW'(-a)  : MW'(a);
    bm1   <= b[MW-1]  ? MW'(-b)  : MW'(b);
    dxm1  <= dx[MW-1] ? MW'(-dx) : MW'(dx);
    dym1  <= dy[MW-1] ? MW'(-dy) : MW'(dy);
    an1   <= a[MW-1];
    bn1   <= b[MW-1];
    dxn1  <= dx[MW-1];
    dyn1  <= dy[MW-1];
  end

  // stage 2: dot product terms and squared length terms
  logic           v2;
  side_t          side2;
  logic [PRW-1:0] p1_2, p2_2, aa2, bb2;
  logic [MW-1:0]  am2, bm2;
  logic           an2, bn2, s1_2, s2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    side2 <= side1;
    p1_2  <= PRW'(am1) * PRW'(dxm1);
    p2_2  <= PRW'(bm1) * PRW'(dym1);
    aa2   <= PRW'(am1) * PRW'(am1);
    bb2   <= PRW'(bm1) * PRW'(bm1);
    am2   <= am1;
    bm2   <= bm1;
    an2   <= an1;
    bn2   <= bn1;
    s1_2  <= an1 ^ dxn1;
    s2_2  <= bn1 ^ dyn1;
  end

  // stage 3: signed dot product as sign and magnitude, divisor
  logic [PRW-1:0] nm_next;
  logic           nneg;
  side_t          side3_next;

  always_comb begin
    if (s1_2 == s2_2) begin
      nm_next = p1_2 + p2_2;
      nneg    = s1_2;
    end else if (p1_2 >= p2_2) begin
      nm_next = p1_2 - p2_2;
      nneg    = s1_2;
    end else begin
      nm_next = p2_2 - p1_2;
      nneg    = s2_2;
    end
    side3_next       = side2;
    side3_next.neg_x = an2 ^ nneg;
    side3_next.neg_y = bn2 ^ nneg;
  end

  logic           v3;
  side_t          side3;
  logic [PRW-1:0] nm3, den3;
  logic [MW-1:0]  am3, bm3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    side3 <= side3_next;
    nm3   <= nm_next;
    den3  <= aa2 + bb2;
    am3   <= am2;
    bm3   <= bm2;
  end

  // stage 4: dot product times direction, split into half-width products
  logic           v4;
  side_t          side4;
  logic [PRW-1:0] xl4, xh4, yl4, yh4, den4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    side4 <= side3;
    den4  <= den3;
    xl4   <= PRW'(nm3[MW-1:0])   * PRW'(am3);
    xh4   <= PRW'(nm3[PRW-1:MW]) * PRW'(am3);
    yl4   <= PRW'(nm3[MW-1:0])   * PRW'(bm3);
    yh4   <= PRW'(nm3[PRW-1:MW]) * PRW'(bm3);
  end

  // stage 5: assemble dividends with fraction bits
  logic           v5;
  side_t          side5;
  logic [RW-1:0]  numx5, numy5;
  logic [PRW-1:0] den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    side5 <= side4;
    den5  <= den4;
    numx5 <= ((RW'(xh4) << MW) + RW'(xl4)) << FRAC_BITS;
    numy5 <= ((RW'(yh4) << MW) + RW'(yl4)) << FRAC_BITS;
  end

  // divider stages, x and y side by side
  logic           dvx, dvy;
  logic [QW-1:0]  qx, qy;
  logic [PRW-1:0] rx, ry, dnx, dny;

  pseg_div #(.DEN_W(PRW), .QUO_W(QW)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .num       (numx5),
    .den       (den5),
    .out_valid (dvx),
    .quo       (qx),
    .rem       (rx),
    .den_out   (dnx)
  );

  pseg_div #(.DEN_W(PRW), .QUO_W(QW)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .num       (numy5),
    .den       (den5),
    .out_valid (dvy),
    .quo       (qy),
    .rem       (ry),
    .den_out   (dny)
  );

  // side data delay matching the divider
  side_t side_d [QW];

  always_ff @(posedge clk) begin
    side_d[0] <= side5;
    for (int i = 1; i < QW; i++) begin
      side_d[i] <= side_d[i-1];
    end
  end

  // post stage 1: round quotients half away from zero, apply sign
  side_t       sd;
  logic [QW:0] qxr, qyr;

  always_comb begin
    sd  = side_d[QW-1];
    qxr = (QW+1)'(qx) + (({rx, 1'b0} >= {1'b0, dnx}) ? (QW+1)'(1) : '0);
    qyr = (QW+1)'(qy) + (({ry, 1'b0} >= {1'b0, dny}) ? (QW+1)'(1) : '0);
  end

  logic               vr;
  side_t              sdr;
  logic signed [QW:0] offx, offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else begin
      vr <= dvx && dvy;
    end
    sdr  <= sd;
    offx <= sd.neg_x ? -$signed(qxr) : $signed(qxr);
    offy <= sd.neg_y ? -$signed(qyr) : $signed(qyr);
  end

  // post stage 2: pick projection, error vector
  logic signed [PW-1:0] bxs, bys, xps, yps, pxq_next, pyq_next;
  logic signed [EW-1:0] ex_next, ey_next;

  always_comb begin
    bxs  = PW'(sdr.bx) <<< FRAC_BITS;
    bys  = PW'(sdr.by) <<< FRAC_BITS;
    xps  = PW'(sdr.px) <<< FRAC_BITS;
    yps  = PW'(sdr.py) <<< FRAC_BITS;
    if (sdr.force_hit) begin
      pxq_next = bxs;
      pyq_next = bys;
    end else if (sdr.vert) begin
      pxq_next = bxs;
      pyq_next = yps;
    end else if (sdr.horz) begin
      pxq_next = xps;
      pyq_next = bys;
    end else begin
      pxq_next = bxs + PW'(offx);
      pyq_next = bys + PW'(offy);
    end
    ex_next = EW'(xps) - EW'(pxq_next);
    ey_next = EW'(yps) - EW'(pyq_next);
  end

  logic                 v6, force6, miss6;
  logic signed [PW-1:0] pxq6, pyq6;
  logic signed [EW-1:0] ex6, ey6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vr;
    end
    force6 <= sdr.force_hit;
    miss6  <= sdr.miss;
    pxq6   <= pxq_next;
    pyq6   <= pyq_next;
    ex6    <= ex_next;
    ey6    <= ey_next;
  end

  // post stage 3: range check, squares, output rounding
  logic [LW-1:0] exm, eym;

  always_comb begin
    exm = ex6[EW-1] ? LW'(-ex6) : LW'(ex6);
    eym = ey6[EW-1] ? LW'(-ey6) : LW'(ey6);
  end

  logic                 v7, force7, miss7, inr7;
  logic [2*LW-1:0]      sqx7, sqy7;
  logic signed [CW-1:0] nx7, ny7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    force7 <= force6;
    miss7  <= miss6;
    inr7   <= (ex6 < Lim) && (ex6 > -Lim) && (ey6 < Lim) && (ey6 > -Lim);
    sqx7   <= (2*LW)'(exm) * (2*LW)'(exm);
    sqy7   <= (2*LW)'(eym) * (2*LW)'(eym);
    nx7    <= rnd_sat(pxq6);
    ny7    <= rnd_sat(pyq6);
  end

  // post stage 4: distance compare, result register
  logic [2*LW:0] d2, thr;
  logic          hit_next;

  always_comb begin
    d2       = (2*LW+1)'(sqx7) + (2*LW+1)'(sqy7);
    thr      = (2*LW+1)'(tol_sq) << (2 * FRAC_BITS);
    hit_next = force7 || (!miss7 && inr7 && (d2 < thr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v7;
    end
    result.hit    <= hit_next;
    result.near_x <= hit_next ? nx7 : '0;
    result.near_y <= hit_next ? ny7 : '0;
  end

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |-> (result.near_x == '0 && result.near_y == '0))
    else $error("miss with nonzero point");

  // pipeline comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

  // every result comes from an earlier transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, LAT))
    else $error("result without transaction");

endmodule
